// ----- rtl/core/gost_pkg.sv -----
// ----------------------------------------------------------------------------
// GOST R 34.11-2012 hash package
// Shared types, constants and LPS transform functions.
// ----------------------------------------------------------------------------
`default_nettype none
package gost_pkg;

  typedef logic [511:0] blk_t;

  localparam logic [63:0] IvWord256 = 64'h0101010101010101;
  localparam int          NumRounds = 12;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_KEY,
    ST_ROUND,
    ST_FINISH,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_BLOCK,
    PH_LEN,
    PH_SUM
  } phase_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } cmp_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] tbl [256];
    tbl = '{
      8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,8'd251,8'd196,8'd250,8'd218,
      8'd35,8'd197,8'd4,8'd77,8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
      8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,8'd249,8'd24,8'd101,8'd90,
      8'd226,8'd92,8'd239,8'd33,8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
      8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,8'd6,8'd11,8'd237,8'd152,
      8'd127,8'd212,8'd211,8'd31,8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
      8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,8'd181,8'd112,8'd14,8'd86,
      8'd8,8'd12,8'd118,8'd18,8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
      8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,8'd243,8'd145,8'd120,8'd111,
      8'd157,8'd158,8'd178,8'd177,8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
      8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,8'd223,8'd245,8'd36,8'd169,
      8'd62,8'd168,8'd67,8'd201,8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
      8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,8'd220,8'd232,8'd40,8'd80,
      8'd78,8'd51,8'd10,8'd74,8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
      8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,8'd173,8'd69,8'd70,8'd146,
      8'd39,8'd94,8'd85,8'd47,8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
      8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,8'd48,8'd55,8'd107,8'd228,
      8'd136,8'd217,8'd231,8'd137,8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
      8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,8'd32,8'd113,8'd103,8'd164,
      8'd45,8'd43,8'd9,8'd91,8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
      8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,8'd209,8'd102,8'd175,8'd194,
      8'd57,8'd75,8'd99,8'd182};
    return tbl[a];
  endfunction

  function automatic logic [63:0] lin_row(input logic [5:0] j);
    logic [63:0] tbl [64];
    tbl = '{
      64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
      64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
      64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
      64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
      64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
      64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
      64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
      64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
      64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
      64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
      64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
      64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
      64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
      64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
      64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
      64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083};
    return tbl[j];
  endfunction

  function automatic logic [511:0] round_const(input logic [3:0] r);
    logic [511:0] tbl [12];
    tbl = '{
      {64'hb1085bda1ecadae9,64'hebcb2f81c0657c1f,64'h2f6a76432e45d016,64'h714eb88d7585c4fc,
       64'h4b7ce09192676901,64'ha2422a08a460d315,64'h05767436cc744d23,64'hdd806559f2a64507},
      {64'h6fa3b58aa99d2f1a,64'h4fe39d460f70b5d7,64'hf3feea720a232b98,64'h61d55e0f16b50131,
       64'h9ab5176b12d69958,64'h5cb561c2db0aa7ca,64'h55dda21bd7cbcd56,64'he679047021b19bb7},
      {64'hf574dcac2bce2fc7,64'h0a39fc286a3d8435,64'h06f15e5f529c1f8b,64'hf2ea7514b1297b7b,
       64'hd3e20fe490359eb1,64'hc1c93a376062db09,64'hc2b6f443867adb31,64'h991e96f50aba0ab2},
      {64'hef1fdfb3e81566d2,64'hf948e1a05d71e4dd,64'h488e857e335c3c7d,64'h9d721cad685e353f,
       64'ha9d72c82ed03d675,64'hd8b71333935203be,64'h3453eaa193e837f1,64'h220cbebc84e3d12e},
      {64'h4bea6bacad474799,64'h9a3f410c6ca92363,64'h7f151c1f1686104a,64'h359e35d7800fffbd,
       64'hbfcd1747253af5a3,64'hdfff00b723271a16,64'h7a56a27ea9ea63f5,64'h601758fd7c6cfe57},
      {64'hae4faeae1d3ad3d9,64'h6fa4c33b7a3039c0,64'h2d66c4f95142a46c,64'h187f9ab49af08ec6,
       64'hcffaa6b71c9ab7b4,64'h0af21f66c2bec6b6,64'hbf71c57236904f35,64'hfa68407a46647d6e},
      {64'hf4c70e16eeaac5ec,64'h51ac86febf240954,64'h399ec6c7e6bf87c9,64'hd3473e33197a93c9,
       64'h0992abc52d822c37,64'h06476983284a0504,64'h3517454ca23c4af3,64'h8886564d3a14d493},
      {64'h9b1f5b424d93c9a7,64'h03e7aa020c6e4141,64'h4eb7f8719c36de1e,64'h89b4443b4ddbc49a,
       64'hf4892bcb929b0690,64'h69d18d2bd1a5c42f,64'h36acc2355951a8d9,64'ha47f0dd4bf02e71e},
      {64'h378f5a541631229b,64'h944c9ad8ec165fde,64'h3a7d3a1b25894224,64'h3cd955b7e00d0984,
       64'h800a440bdbb2ceb1,64'h7b2b8a9aa6079c54,64'h0e38dc92cb1f2a60,64'h7261445183235adb},
      {64'habbedea680056f52,64'h382ae548b2e4f3f3,64'h8941e71cff8a78db,64'h1fffe18a1b336103,
       64'h9fe76702af69334b,64'h7a1e6c303b7652f4,64'h3698fad1153bb6c3,64'h74b4c7fb98459ced},
      {64'h7bcd9ed0efc889fb,64'h3002c6cd635afe94,64'hd8fa6bbbebab0761,64'h2001802114846679,
       64'h8a1d71efea48b9ca,64'hefbacd1d7d476e98,64'hdea2594ac06fd85d,64'h6bcaa4cd81f32d1b},
      {64'h378ee767f11631ba,64'hd21380b00449b17a,64'hcda43c32bcdf1d77,64'hf82012d430219f9b,
       64'h5d80ef9d1891cc86,64'he71da4aa88e12852,64'hfaf417d5d9b21b99,64'h48bc924af11bd720}};
    return tbl[r];
  endfunction

  // Word 0 is held in bits 511:448.
  function automatic logic [511:0] lps(input logic [511:0] v);
    logic [511:0] s;
    logic [511:0] t;
    logic [511:0] o;
    logic [63:0]  acc;
    for (int i = 0; i < 64; i++) begin
      s[i*8 +: 8] = sbox(v[i*8 +: 8]);
    end
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        t[(7-j)*64 + (7-i)*8 +: 8] = s[(7-i)*64 + (7-j)*8 +: 8];
      end
    end
    for (int i = 0; i < 8; i++) begin
      acc = '0;
      for (int j = 0; j < 64; j++) begin
        if (t[(7-i)*64 + 63 - j]) begin
          acc = acc ^ lin_row(6'(j));
        end
      end
      o[(7-i)*64 +: 64] = acc;
    end
    return o;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/gost_if.sv -----
// ----------------------------------------------------------------------------
// GOST hash channel interfaces
// Valid/ready channels for input words, digest words and configuration.
// ----------------------------------------------------------------------------
`default_nettype none
interface gost_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic        message_end;
  logic [8:0]  final_bits;
  modport source (output valid, data_word, message_end, final_bits, input ready);
  modport sink (input valid, data_word, message_end, final_bits, output ready);
endinterface

interface gost_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        digest_last;
  modport source (output valid, digest_word, digest_last, input ready);
  modport sink (input valid, digest_word, digest_last, output ready);
endinterface

interface gost_cfg_if;
  logic valid;
  logic ready;
  logic digest_256;
  modport source (output valid, digest_256, input ready);
  modport sink (input valid, digest_256, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/gost_compress.sv -----
// ----------------------------------------------------------------------------
// GOST compression unit
// Computes g_N(h, m) with one shared LPS unit, one transform per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module gost_compress (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire gost_pkg::blk_t h_in,
  input  wire gost_pkg::blk_t n_in,
  input  wire gost_pkg::blk_t m_in,
  output gost_pkg::cmp_ctl_t ctl,
  output gost_pkg::blk_t     h_out
);
  import gost_pkg::*;

  blk_t       k_r, k_nxt, x_r, x_nxt;
  logic [3:0] rnd_r, rnd_nxt;
  logic [1:0] step_r, step_nxt;
  logic       busy_r, busy_nxt, done_r, done_nxt;
  blk_t       lps_in, lps_out;

  assign lps_out = lps(lps_in);

  // Steps: 0 key setup, 1 x round, 2 key round.
  always_comb begin
    k_nxt    = k_r;
    x_nxt    = x_r;
    rnd_nxt  = rnd_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    lps_in   = x_r ^ k_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      step_nxt = 2'd0;
      rnd_nxt  = '0;
      x_nxt    = m_in;
      k_nxt    = h_in ^ n_in;
    end else if (busy_r) begin
      case (step_r)
        2'd0: begin
          lps_in   = k_r;
          k_nxt    = lps_out;
          step_nxt = 2'd1;
        end
        2'd1: begin
          lps_in   = x_r ^ k_r;
          x_nxt    = lps_out;
          step_nxt = 2'd2;
        end
        default: begin
          lps_in = k_r ^ round_const(rnd_r);
          k_nxt  = lps_out;
          if (rnd_r == 4'(NumRounds - 1)) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end else begin
            rnd_nxt  = rnd_r + 4'd1;
            step_nxt = 2'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    x_r   <= x_nxt;
    rnd_r <= rnd_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;
  assign h_out     = h_in ^ x_r ^ k_r ^ m_in;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without busy");
  a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while busy");
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rnd_r < 4'(NumRounds)) else $error("round out of range");
endmodule
`default_nettype wire

// ----- rtl/core/gost_34_11_2012_hash_core.sv -----
// ----------------------------------------------------------------------------
// GOST R 34.11-2012 hash core
// Buffers message words, sequences compressions and emits the digest.
// ----------------------------------------------------------------------------
// Usage: words arrive on the in channel, eight per 512-bit block, most
// significant first. Each of the first seven words is a single transfer.
// The eighth word starts a compression through the shared LPS unit (key
// setup, then twelve x and key rounds); in_ready stays low through the
// key, round and finish states until the core is back in load. The length
// counter and block sum are updated one word per cycle under the rounds.
// A final block (message_end set) runs three compressions and then
// presents 4 or 8 digest words on the out channel, one per transfer; a
// stalled receiver holds the current word and the core waits. Reset and
// every cfg transfer load the IV for the selected size and clear the
// length counter, block sum and word index. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none
module gost_34_11_2012_hash_core (
  input wire logic  clk,
  input wire logic  rst_n,
  gost_in_if.sink   in_ch,
  gost_out_if.source out_ch,
  gost_cfg_if.sink  cfg_ch
);
  import gost_pkg::*;

  state_t     state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic       d256_r;
  blk_t       h_r, n_r, sum_r, buf_r, m_r;
  logic [2:0] idx_r;
  logic [2:0] ocnt_r;
  logic       cstart;
  blk_t       cn, cm, hnew;
  cmp_ctl_t   cctl;
  logic       in_fire, out_fire;
  logic [8:0] fbits;
  blk_t       pad_m, mask;
  logic       m_fin_r;
  logic [8:0] add_r;
  logic       add_on_r;
  logic [2:0] aidx_r;
  logic       nc_r, sc_r;
  logic [63:0] nadd;
  logic [64:0] nsum, ssum;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  gost_compress u_cmp (
    .clk(clk), .rst_n(rst_n), .start(cstart), .h_in(h_r), .n_in(cn), .m_in(cm),
    .ctl(cctl), .h_out(hnew)
  );

  assign cn = (phase_r == PH_BLOCK) ? n_r : '0;
  always_comb begin
    unique case (phase_r)
      PH_LEN:  cm = n_r;
      PH_SUM:  cm = sum_r;
      default: cm = m_r;
    endcase
  end

  assign fbits = in_ch.final_bits;
  always_comb begin
    blk_t full;
    full = {buf_r[447:0], in_ch.data_word};
    mask = (512'd1 << fbits) - 512'd1;
    pad_m = (full & mask) | (512'd1 << fbits);
  end

  // Word 0 of the addition is the least significant word.
  assign nadd = (aidx_r != 3'd0) ? 64'd0 : (m_fin_r ? {55'd0, add_r} : 64'd512);
  assign nsum = {1'b0, n_r[aidx_r*64 +: 64]} + {1'b0, nadd} + {64'd0, nc_r};
  assign ssum = {1'b0, sum_r[aidx_r*64 +: 64]} + {1'b0, m_r[aidx_r*64 +: 64]} +
                {64'd0, sc_r};

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cstart    = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (in_fire && idx_r == 3'd7) begin
          state_nxt = ST_KEY;
          phase_nxt = PH_BLOCK;
        end
      end
      ST_KEY: begin
        cstart    = 1'b1;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (cctl.done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (phase_r == PH_SUM) begin
          state_nxt = ST_EMIT;
        end else if (phase_r == PH_LEN) begin
          phase_nxt = PH_SUM;
          state_nxt = ST_KEY;
        end else if (m_fin_r) begin
          phase_nxt = PH_LEN;
          state_nxt = ST_KEY;
        end else begin
          state_nxt = ST_LOAD;
        end
      end
      ST_EMIT: begin
        if (out_fire && out_ch.digest_last) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  assign in_ch.ready = (state_r == ST_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      phase_r  <= PH_BLOCK;
      d256_r   <= 1'b1;
      h_r      <= {8{IvWord256}};
      n_r      <= '0;
      sum_r    <= '0;
      idx_r    <= '0;
      ocnt_r   <= '0;
      m_fin_r  <= 1'b0;
      add_on_r <= 1'b0;
      aidx_r   <= '0;
      nc_r     <= 1'b0;
      sc_r     <= 1'b0;
    end else if (cfg_ch.valid) begin
      state_r  <= ST_LOAD;
      phase_r  <= PH_BLOCK;
      d256_r   <= cfg_ch.digest_256;
      h_r      <= cfg_ch.digest_256 ? {8{IvWord256}} : '0;
      n_r      <= '0;
      sum_r    <= '0;
      idx_r    <= '0;
      ocnt_r   <= '0;
      add_on_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (in_fire) begin
        buf_r <= {buf_r[447:0], in_ch.data_word};
        idx_r <= idx_r + 3'd1;
        if (idx_r == 3'd7) begin
          m_fin_r <= in_ch.message_end;
          m_r     <= in_ch.message_end ? pad_m : {buf_r[447:0], in_ch.data_word};
          add_r   <= in_ch.message_end ? fbits : 9'd0;
        end
      end
      if (state_r == ST_KEY && phase_r == PH_BLOCK) begin
        add_on_r <= 1'b1;
        aidx_r   <= '0;
        nc_r     <= 1'b0;
        sc_r     <= 1'b0;
      end else if (add_on_r) begin
        n_r[aidx_r*64 +: 64]   <= nsum[63:0];
        sum_r[aidx_r*64 +: 64] <= ssum[63:0];
        nc_r   <= nsum[64];
        sc_r   <= ssum[64];
        aidx_r <= aidx_r + 3'd1;
        if (aidx_r == 3'd7) add_on_r <= 1'b0;
      end
      if (state_r == ST_FINISH) begin
        h_r <= hnew;
      end
      if (out_fire) begin
        if (out_ch.digest_last) begin
          ocnt_r <= '0;
          h_r    <= d256_r ? {8{IvWord256}} : '0;
          n_r    <= '0;
          sum_r  <= '0;
        end else begin
          ocnt_r <= ocnt_r + 3'd1;
        end
      end
    end
  end

  assign out_ch.valid       = (state_r == ST_EMIT);
  assign out_ch.digest_word = h_r[(7 - ocnt_r)*64 +: 64];
  assign out_ch.digest_last = d256_r ? (ocnt_r == 3'd3) : (ocnt_r == 3'd7);

  a_ready_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("ready during emit");
  a_emit_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && $past(state_r) != ST_EMIT && !$past(cfg_ch.valid))
    |-> $past(phase_r) == PH_SUM) else $error("emit before sum pass");
  a_ocnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (d256_r && state_r == ST_EMIT) |-> ocnt_r < 3'd4) else $error("count range");
  a_add_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> !add_on_r) else $error("update still running");
endmodule
`default_nettype wire
